/* hw/rtl/dmp_pkg.sv */
// ----------------------------------------------------------------------------
// dmp_pkg: shared types and constants of the depth min-pool to point block
// Image size, derived widths, arithmetic constants, register indexes,
// the job word from front to back, queue status and the back state type.
// ----------------------------------------------------------------------------
`default_nettype none

package dmp_pkg;

  // image geometry
  localparam int IMAGE_WIDTH  = 100;
  localparam int IMAGE_HEIGHT = 100;

  localparam int COL_W    = $clog2(IMAGE_WIDTH);
  localparam int ROW_W    = $clog2(IMAGE_HEIGHT);
  localparam int SLOTS    = IMAGE_WIDTH / 2;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LAST_COL = (IMAGE_WIDTH / 2) * 2 - 1;
  localparam int LAST_ROW = (IMAGE_HEIGHT / 2) * 2 - 1;

  // projection widths: |pos*256 - center| and its products
  localparam int POS_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int MAG_W  = (POS_W + 8 > 15) ? POS_W + 8 : 15;
  localparam int PROJ_W = MAG_W + 16;
  localparam int PROD_W = 18 + PROJ_W;
  localparam int QUO_W  = PROD_W - 23;

  // depth code and distance constants: x = round(p*p*65536/26010)
  localparam logic [7:0]  CODE_NONE  = 8'd255;
  localparam logic [14:0] DIST_DIV   = 15'd26010;
  localparam logic [13:0] DIST_HALF  = 14'd13005;
  // floor(2^32 / 26010): estimate is at most two below the rounded quotient
  localparam logic [17:0] DIST_RECIP = 18'd165127;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTRINSICS_RDY = 3'd4;

  localparam logic [15:0] INV_FOCAL_RESET = 16'd873;
  localparam logic [14:0] CENTER_RESET    = 15'd12800;

  // one 2x2 block winner
  typedef struct packed {
    logic [7:0]       code;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             frame_end;
  } job_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_RECIP,
    BK_REMAIN,
    BK_FIX,
    BK_PROD,
    BK_DONE
  } back_state_e;

endpackage

`default_nettype wire

/* hw/rtl/dmp_fifo.sv */
// ----------------------------------------------------------------------------
// dmp_fifo: job queue between front and back
// Small register queue of block winners; the back pops at its own pace.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  dmp_pkg::job_t          job_i,
  input  wire                    pop_i,
  output dmp_pkg::job_t          job_o,
  output dmp_pkg::queue_status_t status_o
);

  dmp_pkg::job_t                   mem_q [dmp_pkg::QUEUE_DEPTH];
  logic [dmp_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [dmp_pkg::QCNT_W-1:0]      count_q;
  logic                            do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  assign job_o          = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;

endmodule

`default_nettype wire

/* hw/rtl/dmp_front.sv */
// ----------------------------------------------------------------------------
// dmp_front: pixel intake and 2x2 minimum pooling
// Tracks column and row, keeps pair minima of even rows in a line store,
// and on odd rows, with intrinsics ready, pushes each block's winner as a job.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          push,
  input  wire  [7:0]                   depth_code_i,
  input  wire                          frame_start_i,
  input  wire                          ready_i,
  input  dmp_pkg::queue_status_t       qstat_i,
  output logic                         full,
  output logic                         q_push_o,
  output dmp_pkg::job_t                q_job_o
);

  logic [dmp_pkg::COL_W-1:0]  col_q, col_cur;
  logic [dmp_pkg::ROW_W-1:0]  row_q, row_cur;
  logic [dmp_pkg::COL_W:0]    col_inc;
  logic [dmp_pkg::ROW_W:0]    row_inc;
  logic [7:0]                 left_q;
  logic [8:0]                 store_q [dmp_pkg::SLOTS];
  logic [8:0]                 top_q;
  logic [dmp_pkg::SLOT_W-1:0] slot;
  logic                       accept, bright, emit;
  logic [7:0]                 bmin;

  // stage 1 registers: bottom pair of the block
  logic                       s1_valid_q;
  logic [7:0]                 s1_min_q;
  logic                       s1_bright_q;
  logic [dmp_pkg::COL_W-1:0]  s1_col_q;
  logic [dmp_pkg::ROW_W-1:0]  s1_row_q;

  // room must exist for the word still in stage 1
  assign full = ({1'b0, qstat_i.count} + {{dmp_pkg::QCNT_W{1'b0}}, s1_valid_q})
                >= (dmp_pkg::QCNT_W + 1)'(dmp_pkg::QUEUE_DEPTH);
  assign accept = push && !full;

  // position of this pixel
  assign col_cur = frame_start_i ? '0 : col_q;
  assign row_cur = frame_start_i ? '0 : row_q;
  assign col_inc = {1'b0, col_cur} + 1'b1;
  assign row_inc = {1'b0, row_cur} + 1'b1;
  assign slot    = col_cur[dmp_pkg::SLOT_W:1];

  // pair minimum, left pixel wins ties
  assign bright = depth_code_i < left_q;
  assign bmin   = bright ? depth_code_i : left_q;
  assign emit   = accept && col_cur[0] && row_cur[0] && ready_i;

  // counters, left hold, stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= emit;
      if (accept) begin
        if (!col_cur[0]) left_q <= depth_code_i;
        if (col_inc >= (dmp_pkg::COL_W + 1)'(dmp_pkg::IMAGE_WIDTH)) begin
          col_q <= '0;
          if (row_inc >= (dmp_pkg::ROW_W + 1)'(dmp_pkg::IMAGE_HEIGHT)) begin
            row_q <= '0;
          end else begin
            row_q <= row_inc[dmp_pkg::ROW_W-1:0];
          end
        end else begin
          col_q <= col_inc[dmp_pkg::COL_W-1:0];
          row_q <= row_cur;
        end
      end
    end
  end

  // line store: written on even rows, read on odd rows
  always_ff @(posedge clk_i) begin
    if (accept && col_cur[0] && !row_cur[0]) store_q[slot] <= {bright, bmin};
    if (emit) top_q <= store_q[slot];
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_min_q    <= bmin;
      s1_bright_q <= bright;
      s1_col_q    <= col_cur;
      s1_row_q    <= row_cur;
    end
  end

  // block winner: top pair wins ties, being earlier in raster order
  always_comb begin
    q_push_o = s1_valid_q;
    if (top_q[7:0] <= s1_min_q) begin
      q_job_o.code = top_q[7:0];
      q_job_o.col  = {s1_col_q[dmp_pkg::COL_W-1:1], top_q[8]};
      q_job_o.row  = {s1_row_q[dmp_pkg::ROW_W-1:1], 1'b0};
    end else begin
      q_job_o.code = s1_min_q;
      q_job_o.col  = {s1_col_q[dmp_pkg::COL_W-1:1], s1_bright_q};
      q_job_o.row  = s1_row_q;
    end
    q_job_o.frame_end = (s1_row_q == dmp_pkg::ROW_W'(dmp_pkg::LAST_ROW)) &&
                        (s1_col_q == dmp_pkg::COL_W'(dmp_pkg::LAST_COL));
  end

endmodule

`default_nettype wire

/* hw/rtl/dmp_back.sv */
// ----------------------------------------------------------------------------
// dmp_back: point arithmetic sequencer
// Turns a block winner into a point: squared code times a reciprocal with
// correction for distance, then offset times focal reciprocal times distance
// for the two lateral axes, rounded and saturated. Holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  dmp_pkg::job_t                q_job_i,
  input  dmp_pkg::queue_status_t       qstat_i,
  output logic                         q_pop_o,
  input  wire  [15:0]                  inv_focal_x_i,
  input  wire  [15:0]                  inv_focal_y_i,
  input  wire  [14:0]                  center_col_i,
  input  wire  [14:0]                  center_row_i,
  input  wire                          pop,
  output logic                         empty,
  output logic [17:0]                  forward_dist_o,
  output logic signed [23:0]           lateral_pos_o,
  output logic signed [23:0]           vertical_pos_o,
  output logic                         point_valid_o,
  output logic                         frame_end_o
);

  localparam int MW = dmp_pkg::MAG_W;
  localparam int PW = dmp_pkg::PROJ_W;
  localparam int DW = dmp_pkg::PROD_W;

  dmp_pkg::back_state_e state_q, state_d;
  dmp_pkg::job_t        job_q;

  logic [15:0]   sq_q;
  logic [17:0]   est_q, x_q;
  logic [16:0]   rem_q;
  logic          negc_q, negr_q;
  logic [MW-1:0] magc_q, magr_q;
  logic [PW-1:0] tc_q, tr_q;
  logic [DW-1:0] pc_q, pr_q;
  logic          out_valid_q, out_load;

  logic [MW:0]   diffc, diffr, ndiffc, ndiffr;
  logic [33:0]   est_full;
  logic [32:0]   rem_full;

  // result rounding and saturation, sign flipped as for y = -x*(pos-center)
  function automatic logic [23:0] sat_proj(input logic [DW-1:0] prod, input logic neg);
    logic [DW:0]                sum;
    logic [dmp_pkg::QUO_W-1:0]  quo;
    logic                       big;
    logic [23:0]                mag;
    sum = {1'b0, prod} + (DW + 1)'(24'h800000);
    quo = sum[DW:24];
    big = (quo >> 23) != '0;
    if (neg) begin
      mag = big ? 24'h7FFFFF : quo[23:0];
      sat_proj = mag;
    end else begin
      mag = big ? 24'h800000 : quo[23:0];
      sat_proj = -mag;
    end
  endfunction

  // offsets pos*256 - center
  assign diffc  = (MW + 1)'({job_q.col, 8'h00}) - (MW + 1)'(center_col_i);
  assign diffr  = (MW + 1)'({job_q.row, 8'h00}) - (MW + 1)'(center_row_i);
  assign ndiffc = -diffc;
  assign ndiffr = -diffr;

  assign est_full = 34'(sq_q) * 34'(dmp_pkg::DIST_RECIP);
  assign rem_full = 33'({sq_q, 16'h0000}) + 33'(dmp_pkg::DIST_HALF)
                  - 33'(est_q) * 33'(dmp_pkg::DIST_DIV);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dmp_pkg::BK_IDLE:   if (!qstat_i.empty) state_d = dmp_pkg::BK_SQUARE;
      dmp_pkg::BK_SQUARE: state_d = dmp_pkg::BK_RECIP;
      dmp_pkg::BK_RECIP:  state_d = dmp_pkg::BK_REMAIN;
      dmp_pkg::BK_REMAIN: state_d = dmp_pkg::BK_FIX;
      dmp_pkg::BK_FIX:    state_d = dmp_pkg::BK_PROD;
      dmp_pkg::BK_PROD:   state_d = dmp_pkg::BK_DONE;
      dmp_pkg::BK_DONE:   if (!out_valid_q || pop) state_d = dmp_pkg::BK_IDLE;
      default:            state_d = dmp_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop_o  = (state_q == dmp_pkg::BK_IDLE) && !qstat_i.empty;
    out_load = (state_q == dmp_pkg::BK_DONE) && (!out_valid_q || pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmp_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)                 out_valid_q <= 1'b1;
      else if (pop && out_valid_q)  out_valid_q <= 1'b0;
    end
  end

  // datapath, one step per state
  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_job_i;
    case (state_q)
      dmp_pkg::BK_SQUARE: begin
        sq_q   <= 16'(job_q.code) * 16'(job_q.code);
        negc_q <= diffc[MW];
        negr_q <= diffr[MW];
        magc_q <= diffc[MW] ? ndiffc[MW-1:0] : diffc[MW-1:0];
        magr_q <= diffr[MW] ? ndiffr[MW-1:0] : diffr[MW-1:0];
      end
      dmp_pkg::BK_RECIP: begin
        est_q <= est_full[33:16];
        tc_q  <= PW'(magc_q) * PW'(inv_focal_x_i);
        tr_q  <= PW'(magr_q) * PW'(inv_focal_y_i);
      end
      dmp_pkg::BK_REMAIN: rem_q <= rem_full[16:0];
      dmp_pkg::BK_FIX: begin
        if (rem_q >= 17'(2 * dmp_pkg::DIST_DIV))  x_q <= est_q + 18'd2;
        else if (rem_q >= 17'(dmp_pkg::DIST_DIV)) x_q <= est_q + 18'd1;
        else                          x_q <= est_q;
      end
      dmp_pkg::BK_PROD: begin
        pc_q <= DW'(x_q) * DW'(tc_q);
        pr_q <= DW'(x_q) * DW'(tr_q);
      end
      default: ;
    endcase
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      frame_end_o <= job_q.frame_end;
      if (job_q.code == dmp_pkg::CODE_NONE) begin
        forward_dist_o <= '0;
        lateral_pos_o  <= '0;
        vertical_pos_o <= '0;
        point_valid_o  <= 1'b0;
      end else begin
        forward_dist_o <= x_q;
        lateral_pos_o  <= sat_proj(pc_q, negc_q);
        vertical_pos_o <= sat_proj(pr_q, negr_q);
        point_valid_o  <= 1'b1;
      end
    end
  end

  assign empty = !out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/depth_min_pool_to_point.sv */
// Path: a block's closing pixel passes the front's stage 1 register, the job
//   queue, then sequencer states square, recip, remain, fix, prod, done.
// Throughput: one pixel per cycle while the queue has room; a winner enters
//   the sequencer after the last result word loads, so dense odd rows stall.
// Reset: counters, left hold, queue and result valid flag clear; configuration
//   registers take reset intrinsics; line store and result data stay as is.
// ----------------------------------------------------------------------------
// depth_min_pool_to_point: depth image to point cloud with 2x2 min pooling
// Front pools pixels into block winners, a queue decouples, the back turns
// each winner into a Q16 point. Holds the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_min_pool_to_point (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               push,
  output logic                              full,
  input  wire  [7:0]                        depth_code_i,
  input  wire                               frame_start_i,
  output logic                              empty,
  input  wire                               pop,
  output logic [17:0]                       forward_dist_o,
  output logic signed [23:0]                lateral_pos_o,
  output logic signed [23:0]                vertical_pos_o,
  output logic                              point_valid_o,
  output logic                              frame_end_o,
  input  wire                               cfg_we_i,
  input  wire  [dmp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [dmp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  logic [15:0] inv_focal_x_q, inv_focal_y_q;
  logic [14:0] center_col_q, center_row_q;
  logic        ready_q;

  dmp_pkg::job_t          f_job, q_job;
  dmp_pkg::queue_status_t qstat;
  logic                   f_push, b_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_focal_x_q <= dmp_pkg::INV_FOCAL_RESET;
      inv_focal_y_q <= dmp_pkg::INV_FOCAL_RESET;
      center_col_q  <= dmp_pkg::CENTER_RESET;
      center_row_q  <= dmp_pkg::CENTER_RESET;
      ready_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dmp_pkg::CFG_INV_FOCAL_X:    inv_focal_x_q <= cfg_wdata_i;
        dmp_pkg::CFG_INV_FOCAL_Y:    inv_focal_y_q <= cfg_wdata_i;
        dmp_pkg::CFG_CENTER_COL:     center_col_q  <= cfg_wdata_i[14:0];
        dmp_pkg::CFG_CENTER_ROW:     center_row_q  <= cfg_wdata_i[14:0];
        dmp_pkg::CFG_INTRINSICS_RDY: ready_q       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  dmp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .depth_code_i  (depth_code_i),
    .frame_start_i (frame_start_i),
    .ready_i       (ready_q),
    .qstat_i       (qstat),
    .full          (full),
    .q_push_o      (f_push),
    .q_job_o       (f_job)
  );

  dmp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (f_push),
    .job_i    (f_job),
    .pop_i    (b_pop),
    .job_o    (q_job),
    .status_o (qstat)
  );

  dmp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_job_i        (q_job),
    .qstat_i        (qstat),
    .q_pop_o        (b_pop),
    .inv_focal_x_i  (inv_focal_x_q),
    .inv_focal_y_i  (inv_focal_y_q),
    .center_col_i   (center_col_q),
    .center_row_i   (center_row_q),
    .pop            (pop),
    .empty          (empty),
    .forward_dist_o (forward_dist_o),
    .lateral_pos_o  (lateral_pos_o),
    .vertical_pos_o (vertical_pos_o),
    .point_valid_o  (point_valid_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/dmp_checker.sv */
// ----------------------------------------------------------------------------
// dmp_checker: port-level checks of the depth min-pool to point block
// Watches the result side: invalid and zero-distance points, distance range,
// and a waiting word holding still.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               empty,
  input wire               pop,
  input wire [17:0]        forward_dist_o,
  input wire signed [23:0] lateral_pos_o,
  input wire signed [23:0] vertical_pos_o,
  input wire               point_valid_o,
  input wire               frame_end_o
);

  // a no-return point carries all-zero coordinates
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !point_valid_o) |->
      (forward_dist_o == '0 && lateral_pos_o == '0 && vertical_pos_o == '0))
    else $error("invalid point with nonzero coordinates");

  // distance never exceeds the square of code 254 scaled
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (forward_dist_o <= 18'd162559))
    else $error("forward distance out of range");

  // zero distance projects to the origin
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && point_valid_o && forward_dist_o == '0) |->
      (lateral_pos_o == '0 && vertical_pos_o == '0))
    else $error("zero distance with nonzero offset");

  // a word that is not taken stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=>
      (!empty && $stable(forward_dist_o) && $stable(lateral_pos_o) &&
       $stable(vertical_pos_o) && $stable(point_valid_o) && $stable(frame_end_o)))
    else $error("waiting word changed");

endmodule

bind depth_min_pool_to_point dmp_checker u_dmp_checker (.*);

`default_nettype wire
